/* rtl/lbpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpc_pkg
// shared types and constants for the lzw byte pair compressor
// ----------------------------------------------------------------------------
package lbpc_pkg;

   localparam int HASH_SLOTS_DEF = 131072;

   localparam logic [31:0] HASH_MULT   = 32'h9E3779B1;
   localparam int          HASH_SHIFT  = 7;
   localparam logic [7:0]  LITERAL_TAG = 8'h01;
   localparam logic [7:0]  LOW_START   = 8'h01;
   localparam logic [7:0]  HIGH_START  = 8'h02;
   localparam logic [7:0]  HIGH_LAST   = 8'hFF;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_READ,
      ST_CMP,
      ST_EMIT,
      ST_INSERT,
      ST_INSWRITE,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic accept;
      logic hash;
      logic probe_step;
      logic take_hit;
      logic push_code;
      logic push_final;
      logic ins_write;
      logic ins_at_hash;
      logic ins_wrap;
      logic clear_step;
   } cmd_type;

   typedef struct packed {
      logic in_valid;
      logic present;
      logic eos;
      logic eos_in_now;
      logic rd_valid;
      logic rd_match;
      logic out_free;
      logic wrap;
      logic clr_done;
   } status_type;

endpackage

/* rtl/lbpc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpc_ctrl
// sequencer for lookup, emit, insert and dictionary clearing
// ----------------------------------------------------------------------------
module lbpc_ctrl
   import lbpc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type stat,
   output cmd_type    cmd,
   output logic       in_ready
);

   state_type state_ff, state_in;
   logic      ret_ins_ff, ret_ins_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         ret_ins_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ret_ins_ff <= ret_ins_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      ret_ins_in = ret_ins_ff;
      cmd        = '0;
      in_ready   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clr_done) begin
               state_in = ret_ins_ff ? ST_INSWRITE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            in_ready = 1'b1;
            if (stat.in_valid) begin
               cmd.accept = 1'b1;
               if (stat.present) begin
                  state_in = ST_HASH;
               end else begin
                  state_in = ST_IDLE;
               end
               // a first byte with eos is routed to the flush below
            end
         end
         ST_HASH: begin
            cmd.hash = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (!stat.rd_valid) begin
               state_in = ST_EMIT;
            end else if (stat.rd_match) begin
               cmd.take_hit = 1'b1;
               state_in = stat.eos ? ST_FINAL : ST_IDLE;
            end else begin
               cmd.probe_step = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.push_code = 1'b1;
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: begin
            if (stat.wrap) begin
               cmd.ins_wrap = 1'b1;
               ret_ins_in = 1'b1;
               state_in = ST_CLEAR;
            end else begin
               cmd.ins_write = 1'b1;
               state_in = stat.eos ? ST_FINAL : ST_IDLE;
            end
         end
         ST_INSWRITE: begin
            cmd.ins_write   = 1'b1;
            cmd.ins_at_hash = 1'b1;
            state_in = stat.eos ? ST_FINAL : ST_IDLE;
         end
         ST_FINAL: begin
            if (stat.out_free) begin
               cmd.push_final = 1'b1;
               ret_ins_in = 1'b0;
               state_in = ST_CLEAR;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
      // a first byte that ends the stream goes straight to the flush
      if (state_ff == ST_IDLE && stat.in_valid && !stat.present && stat.eos_in_now) begin
         state_in = ST_FINAL;
      end
   end

endmodule

/* rtl/lbpc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpc_datapath
// dictionary memory, hash, prefix and index registers, result register
// ----------------------------------------------------------------------------
module lbpc_datapath
   import lbpc_pkg::*;
#(
   parameter int HASH_SLOTS = HASH_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  stat,
   input  logic        req_tvalid,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast
);

   localparam int IDX_W = $clog2(HASH_SLOTS);

   logic [40:0]      mem_ram [HASH_SLOTS];
   logic [40:0]      rd_ff;
   logic [7:0]       byte_ff;
   logic             eos_ff;
   logic [15:0]      prefix_ff;
   logic             present_ff;
   logic [7:0]       low_ff, high_ff;
   logic [23:0]      key_ff;
   logic [IDX_W-1:0] hash_idx_ff, probe_idx_ff, clr_addr_ff;
   logic             out_valid_ff;
   logic [15:0]      out_data_ff;
   logic             out_last_ff;

   logic [31:0]      hash_prod;
   logic [7:0]       ins_low, ins_high;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [40:0]      wr_data;
   logic             out_free;

   assign hash_prod = 32'({8'h00, key_ff} * HASH_MULT);
   assign ins_low   = (low_ff == 8'h00) ? LOW_START : low_ff;
   assign ins_high  = (low_ff == 8'h00) ? 8'(high_ff + 8'h01) : high_ff;
   assign out_free  = !out_valid_ff || rsp_tready;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_addr_ff;
      wr_data = '0;
      if (cmd.clear_step) begin
         wr_en = 1'b1;
      end else if (cmd.ins_write) begin
         wr_en   = 1'b1;
         wr_addr = cmd.ins_at_hash ? hash_idx_ff : probe_idx_ff;
         wr_data = {1'b1, key_ff, ins_high, ins_low};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ram[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ram[probe_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         byte_ff <= req_tdata;
         eos_ff  <= req_tlast;
         key_ff  <= {prefix_ff, req_tdata};
      end
      if (cmd.hash) begin
         hash_idx_ff  <= hash_prod[HASH_SHIFT+IDX_W-1:HASH_SHIFT];
         probe_idx_ff <= hash_prod[HASH_SHIFT+IDX_W-1:HASH_SHIFT];
      end else if (cmd.probe_step) begin
         probe_idx_ff <= IDX_W'(probe_idx_ff + 1'b1);
      end
      if (cmd.push_code || cmd.push_final) begin
         out_data_ff <= prefix_ff;
         out_last_ff <= cmd.push_final;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff    <= '0;
         present_ff   <= 1'b0;
         low_ff       <= LOW_START;
         high_ff      <= HIGH_START;
         clr_addr_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept && !present_ff) begin
            prefix_ff  <= {LITERAL_TAG, req_tdata};
            present_ff <= 1'b1;
         end
         if (cmd.take_hit) begin
            prefix_ff <= rd_ff[15:0];
         end
         if (cmd.ins_wrap) begin
            low_ff  <= LOW_START;
            high_ff <= HIGH_START;
         end
         if (cmd.ins_write) begin
            low_ff    <= 8'(ins_low + 8'h01);
            high_ff   <= ins_high;
            prefix_ff <= {LITERAL_TAG, byte_ff};
         end
         if (cmd.push_final) begin
            present_ff <= 1'b0;
            low_ff     <= LOW_START;
            high_ff    <= HIGH_START;
         end
         if (cmd.clear_step) begin
            clr_addr_ff <= IDX_W'(clr_addr_ff + 1'b1);
         end
         if (cmd.push_code || cmd.push_final) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.in_valid   = req_tvalid;
   assign stat.present    = present_ff;
   assign stat.eos        = eos_ff;
   assign stat.eos_in_now = req_tlast;
   assign stat.rd_valid   = rd_ff[40];
   assign stat.rd_match   = (rd_ff[39:16] == key_ff);
   assign stat.out_free   = out_free;
   assign stat.wrap       = (low_ff == 8'h00) && (high_ff == HIGH_LAST);
   assign stat.clr_done   = &clr_addr_ff;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

/* rtl/lzw_byte_pair_compressor_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_byte_pair_compressor_unit
// lzw compressor emitting two-byte codes from a hashed dictionary
// ----------------------------------------------------------------------------
//
// channel   dir  fields (lsb first)                         marker
// req_      in   tdata: data_byte[7:0]                      tlast: end_of_stream
// rsp_      out  tdata: code_first[7:0], code_second[15:8]  tlast: final_code
//
// one byte at a time; a byte whose lookup hits on the first probe passes through
// accept, hash multiply, registered dictionary memory read and compare; each extra
// linear probe repeats the read and compare; a miss adds an emit step, which waits
// for a free output register, and an insert step
// a clearing pass over all HASH_SLOTS entries runs after reset, after each stream end
// and when the high code index wraps; no byte is taken during it
// a result waits in an output register; the flow stalls only on a second result
//
module lzw_byte_pair_compressor_unit
   import lbpc_pkg::*;
#(
   parameter int HASH_SLOTS = HASH_SLOTS_DEF  // power of two
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // code_first, code_second
   output logic        rsp_tlast
);

   cmd_type    cmd;
   status_type stat;

   // sequencer
   lbpc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .stat     (stat),
      .cmd      (cmd),
      .in_ready (req_tready)
   );

   // dictionary, hash and result register
   lbpc_datapath #(
      .HASH_SLOTS (HASH_SLOTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
